// File: sv/odpk_pkg.sv
// ----------------------------------------------------------------------------
// odpk_pkg
// Shared types, widths, register and microcode constants for the oral dose
// pharmacokinetic integrator.
// ----------------------------------------------------------------------------
package odpk_pkg;

  // field widths
  localparam int DOSE_W    = 32;
  localparam int DAYS_W    = 10;
  localparam int RATE_W    = 24;
  localparam int HOURS_W   = 5;
  localparam int AMT_W     = 32;
  localparam int CONC_W    = 32;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 24;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 40;

  // induced rate divide: base * |mult - 1| * days over induction days
  localparam int DIVD_W  = 2 * RATE_W + DAYS_W;
  // euler quotient input width: (rate * amount) >> 16
  localparam int X_W     = AMT_W + RATE_W - 16;
  localparam int RECIP_W = X_W + 2;

  localparam logic [RATE_W-1:0]  Q16_ONE   = 24'd65536;
  localparam logic [HOURS_W-1:0] MAX_HOURS = 5'd24;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ABSORB_RATE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_ELIM_RATE_BASE = 3'd1;
  localparam logic [IDX_W-1:0] REG_INDUCTION_MULT = 3'd2;
  localparam logic [IDX_W-1:0] REG_INDUCTION_DAYS = 3'd3;
  localparam logic [IDX_W-1:0] REG_INV_VOLUME     = 3'd4;
  localparam logic [IDX_W-1:0] REG_HOURS_PER_DAY  = 3'd5;

  typedef logic [3:0] op_t;
  typedef logic [2:0] cond_t;
  typedef logic [3:0] addr_t;

  // datapath operations
  localparam op_t OP_NOP        = 4'd0;
  localparam op_t OP_LOAD       = 4'd1;
  localparam op_t OP_RATE_MUL1  = 4'd2;
  localparam op_t OP_RATE_MUL2  = 4'd3;
  localparam op_t OP_DIV_START  = 4'd4;
  localparam op_t OP_RATE_DONE  = 4'd5;
  localparam op_t OP_STEP_MUL   = 4'd6;
  localparam op_t OP_STEP_PART  = 4'd7;
  localparam op_t OP_STEP_SUM   = 4'd8;
  localparam op_t OP_STEP_UPD   = 4'd9;
  localparam op_t OP_CONC_MUL   = 4'd10;
  localparam op_t OP_EMIT       = 4'd11;

  // jump conditions
  localparam cond_t C_NEXT      = 3'd0;
  localparam cond_t C_ALWAYS    = 3'd1;
  localparam cond_t C_NO_INPUT  = 3'd2;
  localparam cond_t C_DIV_BUSY  = 3'd3;
  localparam cond_t C_OUT_FULL  = 3'd4;
  localparam cond_t C_STEP_MORE = 3'd5;
  localparam cond_t C_HOUR_MORE = 3'd6;

  // program addresses
  localparam addr_t A_IDLE      = 4'd0;
  localparam addr_t A_RATE_MUL1 = 4'd1;
  localparam addr_t A_RATE_MUL2 = 4'd2;
  localparam addr_t A_DIV_START = 4'd3;
  localparam addr_t A_DIV_WAIT  = 4'd4;
  localparam addr_t A_RATE_DONE = 4'd5;
  localparam addr_t A_STEP_MUL  = 4'd6;
  localparam addr_t A_STEP_PART = 4'd7;
  localparam addr_t A_STEP_SUM  = 4'd8;
  localparam addr_t A_STEP_UPD  = 4'd9;
  localparam addr_t A_CONC_MUL  = 4'd10;
  localparam addr_t A_EMIT      = 4'd11;
  localparam addr_t A_HOUR_END  = 4'd12;
  localparam addr_t A_DAY_END   = 4'd13;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    addr_t target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_full;
    logic step_more;
    logic hour_more;
  } status_t;

  // control store: one word per program step
  function automatic ucode_t ucode_rom(input addr_t addr);
    ucode_t w;
    case (addr)
      A_IDLE:      w = '{OP_LOAD,      C_NO_INPUT,  A_IDLE};
      A_RATE_MUL1: w = '{OP_RATE_MUL1, C_NEXT,      A_IDLE};
      A_RATE_MUL2: w = '{OP_RATE_MUL2, C_NEXT,      A_IDLE};
      A_DIV_START: w = '{OP_DIV_START, C_NEXT,      A_IDLE};
      A_DIV_WAIT:  w = '{OP_NOP,       C_DIV_BUSY,  A_DIV_WAIT};
      A_RATE_DONE: w = '{OP_RATE_DONE, C_NEXT,      A_IDLE};
      A_STEP_MUL:  w = '{OP_STEP_MUL,  C_NEXT,      A_IDLE};
      A_STEP_PART: w = '{OP_STEP_PART, C_NEXT,      A_IDLE};
      A_STEP_SUM:  w = '{OP_STEP_SUM,  C_NEXT,      A_IDLE};
      A_STEP_UPD:  w = '{OP_STEP_UPD,  C_STEP_MORE, A_STEP_MUL};
      A_CONC_MUL:  w = '{OP_CONC_MUL,  C_NEXT,      A_IDLE};
      A_EMIT:      w = '{OP_EMIT,      C_OUT_FULL,  A_EMIT};
      A_HOUR_END:  w = '{OP_NOP,       C_HOUR_MORE, A_STEP_MUL};
      A_DAY_END:   w = '{OP_NOP,       C_ALWAYS,    A_IDLE};
      default:     w = '{OP_NOP,       C_ALWAYS,    A_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: sv/oral_dose_pk_euler_integrator_top.sv
// ----------------------------------------------------------------------------
// oral_dose_pk_euler_integrator_top
// One-compartment oral dose model, forward Euler per hour, one daily request
// in and one concentration request out per hour.
//
//   channel  direction  payload
//   s_*      in         daily request: dose amount, days on drug, start flag
//   m_*      out        hourly concentration, hour index, last-hour mark
//   cfg_*    in         register writes, index and data
//
// From one accepted request to the next, a day runs the induced rate setup and
// then STEPS_PER_HOUR Euler steps per hour: each Euler step passes through the
// multiply, partial product, sum and update steps, and the induced rate waits
// on a bit-serial divider.
// Reset (rst, synchronous) clears the amounts and loads register defaults.
// A stalled output holds the sequencer at the emit step until it is taken;
// a new request is taken once the hour end and day end steps have run after
// the last hour enters the output register.
// ----------------------------------------------------------------------------
module oral_dose_pk_euler_integrator_top #(
  parameter int STEPS_PER_HOUR = 100
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [odpk_pkg::S_TDATA_W-1:0]   s_tdata,   // dose_amount, dose_days
  input  logic                             s_tuser,   // start_drug
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [odpk_pkg::M_TDATA_W-1:0]   m_tdata,   // concentration, hour_index
  output logic                             m_tlast,
  input  logic                             cfg_wr_en,
  input  logic [odpk_pkg::IDX_W-1:0]       cfg_index,
  input  logic [odpk_pkg::CFG_W-1:0]       cfg_data
);

  localparam int DOSE_W = odpk_pkg::DOSE_W;
  localparam int DAYS_W = odpk_pkg::DAYS_W;
  localparam int CONC_W = odpk_pkg::CONC_W;
  localparam int HW     = odpk_pkg::HOURS_W;

  odpk_pkg::op_t          op;
  odpk_pkg::status_t      status;
  logic [CONC_W-1:0]      concentration;
  logic [HW-1:0]          hour_index;

  odpk_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  odpk_datapath #(
    .STEPS_PER_HOUR (STEPS_PER_HOUR)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .in_valid      (s_tvalid),
    .dose_amount   (s_tdata[DOSE_W-1:0]),
    .dose_days     (s_tdata[DOSE_W+DAYS_W-1:DOSE_W]),
    .start_drug    (s_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_ready     (m_tready),
    .in_ready      (s_tready),
    .status        (status),
    .out_valid     (m_tvalid),
    .concentration (concentration),
    .hour_index    (hour_index),
    .last_hour     (m_tlast)
  );

  // output packing, zero fill to whole bytes
  assign m_tdata = {(odpk_pkg::M_TDATA_W - CONC_W - HW)'(0), hour_index, concentration};

endmodule

// File: sv/odpk_divider.sv
// ----------------------------------------------------------------------------
// odpk_divider
// Restoring divider, one quotient bit per cycle, for the induced rate scaling
// by the induction day count.
// ----------------------------------------------------------------------------
module odpk_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [odpk_pkg::DIVD_W-1:0]  dividend,
  input  logic [odpk_pkg::DAYS_W-1:0]  divisor,
  output logic                         busy,
  output logic [odpk_pkg::DIVD_W-1:0]  quotient
);

  localparam int DW    = odpk_pkg::DIVD_W;
  localparam int VW    = odpk_pkg::DAYS_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [VW-1:0]    rem;
  logic [DW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             ge;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quo[DW-1]};
    diff  = trial - {1'b0, divisor};
    ge    = trial >= {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign quotient = quo;

endmodule

// File: sv/odpk_datapath.sv
// ----------------------------------------------------------------------------
// odpk_datapath
// Configuration registers, compartment amounts, multipliers, reciprocal
// division by the step count and the output register, driven by the
// operation code of the sequencer.
// ----------------------------------------------------------------------------
module odpk_datapath #(
  parameter int STEPS_PER_HOUR = 100
) (
  input  logic                          clk,
  input  logic                          rst,
  input  odpk_pkg::op_t                 op,
  input  logic                          in_valid,
  input  logic [odpk_pkg::DOSE_W-1:0]   dose_amount,
  input  logic [odpk_pkg::DAYS_W-1:0]   dose_days,
  input  logic                          start_drug,
  input  logic                          cfg_wr_en,
  input  logic [odpk_pkg::IDX_W-1:0]    cfg_index,
  input  logic [odpk_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          out_ready,
  output logic                          in_ready,
  output odpk_pkg::status_t             status,
  output logic                          out_valid,
  output logic [odpk_pkg::CONC_W-1:0]   concentration,
  output logic [odpk_pkg::HOURS_W-1:0]  hour_index,
  output logic                          last_hour
);

  localparam int RW   = odpk_pkg::RATE_W;
  localparam int AW   = odpk_pkg::AMT_W;
  localparam int DW   = odpk_pkg::DAYS_W;
  localparam int HW   = odpk_pkg::HOURS_W;
  localparam int XW   = odpk_pkg::X_W;
  localparam int QW   = odpk_pkg::DIVD_W;
  localparam int MW   = AW + RW;
  localparam int FW   = XW + odpk_pkg::RECIP_W;
  localparam int LOW  = 32;
  localparam int XHW  = XW - LOW;
  localparam int RHW  = odpk_pkg::RECIP_W - LOW;
  localparam int ADJW = QW - 16;

  // reciprocal of the step count, exact floor for any X_W-bit numerator
  localparam int STEP_LOG    = $clog2(STEPS_PER_HOUR);
  localparam int RECIP_SHIFT = XW + STEP_LOG;
  localparam logic [63:0] RECIP =
    ((64'd1 << RECIP_SHIFT) + 64'(STEPS_PER_HOUR) - 64'd1) / 64'(STEPS_PER_HOUR);
  localparam logic [LOW-1:0] RECIP_LO = RECIP[LOW-1:0];
  localparam logic [RHW-1:0] RECIP_HI = RECIP[odpk_pkg::RECIP_W-1:LOW];

  localparam int STEP_W = $clog2(STEPS_PER_HOUR + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS_PER_HOUR - 1);

  // configuration registers
  logic [RW-1:0] absorb_rate;
  logic [RW-1:0] elim_rate_base;
  logic [RW-1:0] induction_mult;
  logic [DW-1:0] induction_days;
  logic [RW-1:0] inv_volume;
  logic [HW-1:0] hours_per_day;

  // compartment state and per-day values
  logic [AW-1:0]     gut;
  logic [AW-1:0]     central;
  logic [DW-1:0]     days_clip;
  logic [HW-1:0]     hours_lim;
  logic [RW-1:0]     ke;
  logic [STEP_W-1:0] step_cnt;
  logic [HW-1:0]     hour;

  // arithmetic pipeline registers
  logic [2*RW-1:0]    prod_a;
  logic [QW-1:0]      prod_b;
  logic [MW-1:0]      mul_a;
  logic [MW-1:0]      mul_e;
  logic [2*LOW-1:0]   pa0, pe0;
  logic [LOW+RHW-1:0] pa1, pe1;
  logic [XHW+LOW-1:0] pa2, pe2;
  logic [XHW+RHW-1:0] pa3, pe3;
  logic [XW-1:0]      qa, qe;
  logic [MW-1:0]      conc_prod;

  // combinational helpers
  logic [DW-1:0]   ind_t;
  logic            mult_neg;
  logic [RW-1:0]   mult_mag;
  logic [HW-1:0]   hours_in;
  logic [AW:0]     gut_sum;
  logic [AW-1:0]   gut_load;
  logic [ADJW-1:0] adj;
  logic [ADJW:0]   ke_sum;
  logic [RW-1:0]   ke_next;
  logic [XW-1:0]   xa, xe;
  logic [XW+1:0]   c_sum;
  logic            accept;
  logic            emit_fire;
  logic            div_busy;
  logic [QW-1:0]   div_quo;

  // sum of partial products, then the shift of the reciprocal
  function automatic logic [XW-1:0] recip_quot(
    input logic [2*LOW-1:0]   p0,
    input logic [LOW+RHW-1:0] p1,
    input logic [XHW+LOW-1:0] p2,
    input logic [XHW+RHW-1:0] p3
  );
    logic [FW-1:0] full;
    full = FW'(p0) + (FW'(p1) << LOW) + (FW'(p2) << LOW) + (FW'(p3) << (2 * LOW));
    return XW'(full >> RECIP_SHIFT);
  endfunction

  assign in_ready  = (op == odpk_pkg::OP_LOAD);
  assign accept    = in_ready && in_valid;
  assign emit_fire = (op == odpk_pkg::OP_EMIT) && !(out_valid && !out_ready);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      absorb_rate    <= 24'd65536;
      elim_rate_base <= 24'd6554;
      induction_mult <= 24'd65536;
      induction_days <= 10'd1;
      inv_volume     <= 24'd167772;
      hours_per_day  <= 5'd24;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        odpk_pkg::REG_ABSORB_RATE:    absorb_rate    <= cfg_data;
        odpk_pkg::REG_ELIM_RATE_BASE: elim_rate_base <= cfg_data;
        odpk_pkg::REG_INDUCTION_MULT: induction_mult <= cfg_data;
        odpk_pkg::REG_INDUCTION_DAYS: induction_days <= cfg_data[DW-1:0];
        odpk_pkg::REG_INV_VOLUME:     inv_volume     <= cfg_data;
        odpk_pkg::REG_HOURS_PER_DAY:  hours_per_day  <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // per-day setup values
  always_comb begin
    ind_t    = (induction_days == '0) ? DW'(1) : induction_days;
    mult_neg = induction_mult < odpk_pkg::Q16_ONE;
    mult_mag = mult_neg ? (odpk_pkg::Q16_ONE - induction_mult)
                        : (induction_mult - odpk_pkg::Q16_ONE);
    if (hours_per_day == '0) begin
      hours_in = HW'(1);
    end else if (hours_per_day > odpk_pkg::MAX_HOURS) begin
      hours_in = odpk_pkg::MAX_HOURS;
    end else begin
      hours_in = hours_per_day;
    end
    gut_sum  = {1'b0, (start_drug ? '0 : gut)} + {1'b0, dose_amount};
    gut_load = gut_sum[AW] ? '1 : gut_sum[AW-1:0];
  end

  // induced elimination rate from the divider quotient
  always_comb begin
    adj    = div_quo[QW-1:16];
    ke_sum = (ADJW+1)'(elim_rate_base) + (ADJW+1)'(adj);
    if (mult_neg) begin
      ke_next = (adj > ADJW'(elim_rate_base)) ? '0 : (elim_rate_base - adj[RW-1:0]);
    end else begin
      ke_next = (ke_sum[ADJW:RW] != '0) ? '1 : ke_sum[RW-1:0];
    end
  end

  // euler update terms
  always_comb begin
    xa    = mul_a[MW-1:16];
    xe    = mul_e[MW-1:16];
    c_sum = (XW+2)'(central) + (XW+2)'(qa) - (XW+2)'(qe);
  end

  odpk_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (op == odpk_pkg::OP_DIV_START),
    .dividend (prod_b),
    .divisor  (ind_t),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // compartment amounts
  always_ff @(posedge clk) begin
    if (rst) begin
      gut     <= '0;
      central <= '0;
    end else if (accept) begin
      gut     <= gut_load;
      central <= start_drug ? '0 : central;
    end else if (op == odpk_pkg::OP_STEP_UPD) begin
      gut <= (qa >= XW'(gut)) ? '0 : (gut - qa[AW-1:0]);
      if (c_sum[XW+1]) begin
        central <= '0;
      end else if (c_sum[XW:AW] != '0) begin
        central <= '1;
      end else begin
        central <= c_sum[AW-1:0];
      end
    end
  end

  // step and hour counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
      hour     <= '0;
    end else if (op == odpk_pkg::OP_RATE_DONE) begin
      step_cnt <= STEP_LAST;
      hour     <= '0;
    end else if (op == odpk_pkg::OP_STEP_UPD && step_cnt != '0) begin
      step_cnt <= step_cnt - 1'b1;
    end else if (emit_fire) begin
      step_cnt <= STEP_LAST;
      hour     <= hour + 1'b1;
    end
  end

  // payload registers of the day setup and the step arithmetic
  always_ff @(posedge clk) begin
    if (accept) begin
      days_clip <= (dose_days < ind_t) ? dose_days : ind_t;
      hours_lim <= hours_in;
    end
    case (op)
      odpk_pkg::OP_RATE_MUL1: prod_a <= (2*RW)'(elim_rate_base) * (2*RW)'(mult_mag);
      odpk_pkg::OP_RATE_MUL2: prod_b <= QW'(prod_a) * QW'(days_clip);
      odpk_pkg::OP_RATE_DONE: ke     <= ke_next;
      odpk_pkg::OP_STEP_MUL: begin
        mul_a <= MW'(absorb_rate) * MW'(gut);
        mul_e <= MW'(ke) * MW'(central);
      end
      odpk_pkg::OP_STEP_PART: begin
        pa0 <= (2*LOW)'(xa[LOW-1:0]) * (2*LOW)'(RECIP_LO);
        pa1 <= (LOW+RHW)'(xa[LOW-1:0]) * (LOW+RHW)'(RECIP_HI);
        pa2 <= (XHW+LOW)'(xa[XW-1:LOW]) * (XHW+LOW)'(RECIP_LO);
        pa3 <= (XHW+RHW)'(xa[XW-1:LOW]) * (XHW+RHW)'(RECIP_HI);
        pe0 <= (2*LOW)'(xe[LOW-1:0]) * (2*LOW)'(RECIP_LO);
        pe1 <= (LOW+RHW)'(xe[LOW-1:0]) * (LOW+RHW)'(RECIP_HI);
        pe2 <= (XHW+LOW)'(xe[XW-1:LOW]) * (XHW+LOW)'(RECIP_LO);
        pe3 <= (XHW+RHW)'(xe[XW-1:LOW]) * (XHW+RHW)'(RECIP_HI);
      end
      odpk_pkg::OP_STEP_SUM: begin
        qa <= recip_quot(pa0, pa1, pa2, pa3);
        qe <= recip_quot(pe0, pe1, pe2, pe3);
      end
      odpk_pkg::OP_CONC_MUL: conc_prod <= MW'(central) * MW'(inv_volume);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      concentration <= conc_prod[MW-1:RW];
      hour_index    <= hour;
      last_hour     <= (hour + 1'b1) == hours_lim;
    end
  end

  // status to the sequencer
  always_comb begin
    status.in_valid  = in_valid;
    status.div_busy  = div_busy;
    status.out_full  = out_valid && !out_ready;
    status.step_more = step_cnt != '0;
    status.hour_more = hour != hours_lim;
  end

endmodule

// File: sv/odpk_useq.sv
// ----------------------------------------------------------------------------
// odpk_useq
// Microprogram sequencer: step counter, control store lookup and
// conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module odpk_useq (
  input  logic               clk,
  input  logic               rst,
  input  odpk_pkg::status_t  status,
  output odpk_pkg::op_t      op
);

  odpk_pkg::addr_t  pc;
  odpk_pkg::addr_t  pc_next;
  odpk_pkg::ucode_t word;
  logic             take;

  // control word of the current step
  assign word = odpk_pkg::ucode_rom(pc);
  assign op   = word.op;

  // jump condition
  always_comb begin
    case (word.cond)
      odpk_pkg::C_NEXT:      take = 1'b0;
      odpk_pkg::C_ALWAYS:    take = 1'b1;
      odpk_pkg::C_NO_INPUT:  take = !status.in_valid;
      odpk_pkg::C_DIV_BUSY:  take = status.div_busy;
      odpk_pkg::C_OUT_FULL:  take = status.out_full;
      odpk_pkg::C_STEP_MORE: take = status.step_more;
      odpk_pkg::C_HOUR_MORE: take = status.hour_more;
      default:               take = 1'b0;
    endcase
    pc_next = take ? word.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= odpk_pkg::A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: sv/odpk_checker.sv
// ----------------------------------------------------------------------------
// odpk_checker
// Port-level checks of the integrator top, attached by bind.
// ----------------------------------------------------------------------------
module odpk_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [odpk_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                            m_tlast
);

  // after reset the block is idle and ready for a request
  a_reset_idle: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

  // an accepted request starts a day, so no second request follows at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while a day is running");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed under stall");

  // hour index within a day and zero fill
  a_out_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:37] == 3'b000 && m_tdata[36:32] <= 5'd23)
    else $error("bad hour index or fill");

endmodule

bind oral_dose_pk_euler_integrator_top odpk_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
